// ===== src/tts_pkg.sv =====
// Shared types and constants of the tick task table scheduler.
`default_nettype none

package tts_pkg;

    localparam int SLOTS_DEF = 8;

    // Field widths of one input beat and one result beat.
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int TAG_W    = 16;
    localparam int STAT_W   = 3;
    localparam int ACNT_W   = 4;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_CREATE = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NULL_TAG   = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_TAKEN      = 3'd3,
        STAT_EMPTY      = 3'd4,
        STAT_BAD_PERIOD = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREATE,
        S_DEL_RD,
        S_DELETE,
        S_TICK_RD,
        S_TICK_EX,
        S_TICK_END,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_RESP
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;      // take the input beat, clear per-item state
        logic idx_clr;
        logic idx_inc;
        logic rd;           // read the slot memories
        logic rd_slot;      // read address from the beat's slot, else the index
        logic create_exec;
        logic delete_exec;
        logic tick_exec;
        logic resp_load;    // load a plain status result
        logic emit_load;    // load a firing result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_func func;
        logic  idx_last;
        logic  fire_cur;
        logic  emit_last;
        logic  any_fire;
        logic  out_space;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/tts_ctrl.sv =====
// Sequencer of the tick task table scheduler.
`default_nettype none

module tts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_tvalid,
    output logic                o_tready,
    input  wire tts_pkg::t_stat i_stat,
    output tts_pkg::t_cmd       o_cmd
);

    tts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_tready = 1'b0;
        unique case (r_state)
            tts_pkg::S_IDLE: begin
                o_tready = 1'b1;
                if (i_tvalid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state = tts_pkg::S_TICK_RD;
                end
            end
            tts_pkg::S_CREATE: begin
                o_cmd.create_exec = 1'b1;
                n_state = tts_pkg::S_RESP;
            end
            tts_pkg::S_DEL_RD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_slot = 1'b1;
                n_state = tts_pkg::S_DELETE;
            end
            tts_pkg::S_DELETE: begin
                o_cmd.delete_exec = 1'b1;
                n_state = tts_pkg::S_RESP;
            end
            tts_pkg::S_TICK_RD: begin
                // dispatch on the captured function the cycle after accept
                unique case (i_stat.func)
                    tts_pkg::FUNC_TICK: begin
                        o_cmd.rd = 1'b1;
                        n_state = tts_pkg::S_TICK_EX;
                    end
                    tts_pkg::FUNC_CREATE: n_state = tts_pkg::S_CREATE;
                    tts_pkg::FUNC_DELETE: n_state = tts_pkg::S_DEL_RD;
                    default:              n_state = tts_pkg::S_RESP;
                endcase
            end
            tts_pkg::S_TICK_EX: begin
                o_cmd.tick_exec = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = tts_pkg::S_TICK_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = tts_pkg::S_TICK_RD;
                end
            end
            tts_pkg::S_TICK_END: begin
                n_state = i_stat.any_fire ? tts_pkg::S_EMIT_RD : tts_pkg::S_RESP;
            end
            tts_pkg::S_EMIT_RD: begin
                // skip slots that did not fire
                if (i_stat.fire_cur) begin
                    o_cmd.rd = 1'b1;
                    n_state = tts_pkg::S_EMIT_OUT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            tts_pkg::S_EMIT_OUT: begin
                if (i_stat.out_space) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = tts_pkg::S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = tts_pkg::S_EMIT_RD;
                    end
                end
            end
            tts_pkg::S_RESP: begin
                if (i_stat.out_space) begin
                    o_cmd.resp_load = 1'b1;
                    n_state = tts_pkg::S_IDLE;
                end
            end
            default: n_state = tts_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tts_dp.sv =====
// Datapath of the tick task table scheduler: slot table, scan index, result register.
`default_nettype none

module tts_dp #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tts_pkg::IN_W-1:0]    i_tdata,
    input  wire logic [tts_pkg::FUNC_W-1:0]  i_tuser,
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [tts_pkg::OUT_W-1:0]        o_tdata,
    output logic                             o_tuser,
    output logic                             o_tlast,
    input  wire tts_pkg::t_cmd               i_cmd,
    output tts_pkg::t_stat                   o_stat
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // captured beat
    tts_pkg::t_func                 r_func;
    logic [tts_pkg::SLOT_W-1:0]     r_slot;
    logic [tts_pkg::PERIOD_W-1:0]   r_period;
    logic                           r_once;
    logic [tts_pkg::TAG_W-1:0]      r_tag;

    // table state
    logic [SLOTS-1:0]               r_used;
    logic [SLOTS-1:0]               r_os;
    logic [SLOTS-1:0]               r_fire;
    logic [CW-1:0]                  r_count;
    logic [IW-1:0]                  r_idx;
    logic [IW-1:0]                  r_last_fire;
    logic                           r_any_fire;
    tts_pkg::t_status               r_status;

    logic [tts_pkg::PERIOD_W-1:0]   r_mem_period [SLOTS];
    logic [tts_pkg::PERIOD_W-1:0]   r_mem_cnt    [SLOTS];
    logic [tts_pkg::TAG_W-1:0]      r_mem_tag    [SLOTS];
    logic [tts_pkg::PERIOD_W-1:0]   r_rd_period;
    logic [tts_pkg::PERIOD_W-1:0]   r_rd_cnt;
    logic [tts_pkg::TAG_W-1:0]      r_rd_tag;

    // result register
    logic                           r_out_valid;
    logic                           r_out_fired;
    logic [tts_pkg::SLOT_W-1:0]     r_out_slot;
    logic [tts_pkg::TAG_W-1:0]      r_out_tag;
    tts_pkg::t_status               r_out_status;
    logic [tts_pkg::ACNT_W-1:0]     r_out_count;
    logic                           r_out_last;

    logic [7:0]                     slot_ext;
    logic [IW-1:0]                  slot_idx;
    logic                           slot_in_range;
    logic [IW-1:0]                  rd_addr;
    logic                           table_full;
    logic                           cr_ok;
    tts_pkg::t_status               cr_status;
    logic                           dl_hit;
    tts_pkg::t_status               dl_status;
    logic [tts_pkg::PERIOD_W-1:0]   cnt_inc;
    logic                           tk_used;
    logic                           tk_hit;
    logic                           tk_free;
    logic [IW-1:0]                  cnt_addr;
    logic [tts_pkg::PERIOD_W-1:0]   cnt_wdata;
    logic                           cnt_we;
    logic [7:0]                     count_ext;
    logic [7:0]                     idx_ext;

    assign slot_ext      = 8'(r_slot);
    assign slot_idx      = slot_ext[IW-1:0];
    assign slot_in_range = slot_ext < 8'(SLOTS);
    assign rd_addr       = i_cmd.rd_slot ? slot_idx : r_idx;
    assign table_full    = r_count == CW'(SLOTS);
    assign count_ext     = 8'(r_count);
    assign idx_ext       = 8'(r_idx);

    // create checks, first failure wins
    always_comb begin
        cr_ok = 1'b0;
        priority if (table_full) begin
            cr_status = tts_pkg::STAT_FULL;
        end else if (r_tag == '0) begin
            cr_status = tts_pkg::STAT_NULL_TAG;
        end else if (r_period < 16'd2) begin
            cr_status = tts_pkg::STAT_BAD_PERIOD;
        end else if (!slot_in_range || r_used[slot_idx]) begin
            cr_status = tts_pkg::STAT_TAKEN;
        end else begin
            cr_status = tts_pkg::STAT_OK;
            cr_ok     = 1'b1;
        end
    end

    // delete checks; a mismatch is silent
    always_comb begin
        dl_hit = 1'b0;
        priority if (r_tag == '0) begin
            dl_status = tts_pkg::STAT_NULL_TAG;
        end else if (r_count == '0) begin
            dl_status = tts_pkg::STAT_EMPTY;
        end else begin
            dl_status = tts_pkg::STAT_OK;
            dl_hit    = slot_in_range && r_used[slot_idx] && (r_rd_tag == r_tag);
        end
    end

    assign cnt_inc = r_rd_cnt + 16'd1;
    assign tk_used = r_used[r_idx];
    assign tk_hit  = tk_used && (cnt_inc == r_rd_period);
    assign tk_free = tk_hit && r_os[r_idx];

    assign cnt_we    = (i_cmd.create_exec && cr_ok) || (i_cmd.tick_exec && tk_used);
    assign cnt_addr  = i_cmd.create_exec ? slot_idx : r_idx;
    assign cnt_wdata = i_cmd.create_exec ? 16'd1 : (tk_hit ? 16'd0 : cnt_inc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.create_exec && cr_ok) begin
            r_mem_period[slot_idx] <= r_period;
            r_mem_tag[slot_idx]    <= r_tag;
        end
        if (cnt_we) begin
            r_mem_cnt[cnt_addr] <= cnt_wdata;
        end
        // hold read data between reads so a stalled result keeps its tag
        if (i_cmd.rd) begin
            r_rd_period <= r_mem_period[rd_addr];
            r_rd_cnt    <= r_mem_cnt[rd_addr];
            r_rd_tag    <= r_mem_tag[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= tts_pkg::t_func'(i_tuser);
            r_slot   <= i_tdata[2:0];
            r_period <= i_tdata[18:3];
            r_once   <= i_tdata[19];
            r_tag    <= i_tdata[35:20];
        end
        if (i_cmd.tick_exec && tk_hit) begin
            r_last_fire <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_os       <= '0;
            r_fire     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_any_fire <= 1'b0;
            r_status   <= tts_pkg::STAT_OK;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.capture) begin
                r_fire     <= '0;
                r_any_fire <= 1'b0;
                r_status   <= tts_pkg::STAT_OK;
            end
            if (i_cmd.create_exec) begin
                r_status <= cr_status;
                if (cr_ok) begin
                    r_used[slot_idx] <= 1'b1;
                    r_os[slot_idx]   <= r_once;
                    r_count          <= r_count + CW'(1);
                end
            end
            if (i_cmd.delete_exec) begin
                r_status <= dl_status;
                if (dl_hit) begin
                    r_used[slot_idx] <= 1'b0;
                    r_count          <= r_count - CW'(1);
                end
            end
            if (i_cmd.tick_exec && tk_hit) begin
                r_fire[r_idx] <= 1'b1;
                r_any_fire    <= 1'b1;
                if (tk_free) begin
                    r_used[r_idx] <= 1'b0;
                    r_count       <= r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_load || i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out_fired  <= 1'b0;
            r_out_slot   <= '0;
            r_out_tag    <= '0;
            r_out_status <= r_status;
            r_out_count  <= count_ext[tts_pkg::ACNT_W-1:0];
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_out_fired  <= 1'b1;
            r_out_slot   <= idx_ext[tts_pkg::SLOT_W-1:0];
            r_out_tag    <= r_rd_tag;
            r_out_status <= tts_pkg::STAT_OK;
            r_out_count  <= count_ext[tts_pkg::ACNT_W-1:0];
            r_out_last   <= r_idx == r_last_fire;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_out_fired;
    assign o_tlast  = r_out_last;
    assign o_tdata  = {6'd0, r_out_count, r_out_status, r_out_tag, r_out_slot};

    assign o_stat.func      = r_func;
    assign o_stat.idx_last  = r_idx == IW'(SLOTS - 1);
    assign o_stat.fire_cur  = r_fire[r_idx];
    assign o_stat.emit_last = r_idx == r_last_fire;
    assign o_stat.any_fire  = r_any_fire;
    assign o_stat.out_space = !r_out_valid || i_tready;

endmodule

`default_nettype wire

// ===== src/tick_task_table_scheduler_core.sv =====
// Top level of the tick task table scheduler: sequencer, datapath and checks.
//
// A table of SLOTS task slots, the slot index being the task's priority, driven by
// stream beats: tick, create or delete, any other function code getting a plain
// status result. A delete reads its slot before it acts. A tick scans the table
// slot by slot, reading and then updating each, because period, counter and tag
// sit in single-port slot memories with registered reads, then reads and emits
// each firing, skipping idle slots, or gives the plain result when nothing fires;
// results wait for space in the output register. A tick result, or every firing
// result, carries the active count after the whole tick, which is why firings go
// out only after the scan. A new beat is accepted once the previous item's last
// result is in the output register, while that result may still wait for the sink.
// No clearing pass after reset.
`default_nettype none

module tick_task_table_scheduler_core #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot[2:0], period[18:3], once[19], task_tag[35:20], zero fill
    input  wire logic [tts_pkg::IN_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  wire logic [tts_pkg::FUNC_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // fired_slot[2:0], fired_tag[18:3], status[21:19], active_count[25:22], zero fill
    output logic [tts_pkg::OUT_W-1:0]        m_axis_tdata,
    // fired[0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    tts_pkg::t_cmd  cmd;
    tts_pkg::t_stat stat;

    tts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    tts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast),
        .i_cmd    (cmd),
        .o_stat   (stat)
    );

    // a result without a firing is always the only one of its item
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("plain result without last");

    a_fire_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:19] == tts_pkg::STAT_OK)
        else $error("firing result with nonzero status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat accepted while previous item in work");

    a_emit_fired_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_load |-> stat.fire_cur && stat.any_fire)
        else $error("firing result for a slot that did not fire");

endmodule

`default_nettype wire
